FILE: src/dca_pkg.sv
package dca_pkg;

  // Number of live channels, at most eight.
  localparam int CHANNELS = 8;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int DEV_W    = 16;
  localparam int CH_W     = 4;
  localparam int GRANT_W  = 3;
  localparam int MUX_W    = 32;

  // Packed stream widths, padded to whole bytes.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 40;

  localparam logic [MUX_W-1:0] MUX_RESET     = 32'h7654_3210;
  localparam logic [DEV_W-1:0] DEVICE_NIBBLE = 16'h000f;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [DEV_W-1:0] device;
    logic [CH_W-1:0]  channel;
  } req_t;

endpackage

FILE: src/dma_channel_allocator_core.sv
// Pipeline: an accepted item goes from the input register to the result register.
// Throughput: one item per cycle unless the output stalls; the eight-entry owner table
// is searched in parallel and updated in the same cycle that the result register loads.
// Reset: synchronous, active high on rst. All channels become free, owner i holds id i,
// the mux map returns to the identity 0x76543210, and both pipeline registers empty.
module dma_channel_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, from bit 0: device[15:0], channel[19:16], zeros[23:20]
  input  logic [dca_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser, from bit 0: func[0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, from bit 0: granted_channel[2:0], mux_map[34:3], zeros[39:35]
  output logic [dca_pkg::M_DATA_W-1:0]  m_tdata,
  // m_tuser, from bit 0: ok[0]
  output logic                          m_tuser
);
  import dca_pkg::*;

  // Channel table. Owner ids stay behind after a free so that a device
  // tends to get its old channel back without touching the mux map.
  logic [DEV_W-1:0]    owner_id [CHANNELS];
  logic [CHANNELS-1:0] free_flag;
  logic [MUX_W-1:0]    mux_word;

  // Input register.
  logic in_valid;
  req_t in_req;

  // The item in the input register is processed whenever the result
  // register is empty or is being emptied in this cycle.
  logic proc;
  assign proc     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proc;

  // Parallel search over the table, lowest channel wins in each class.
  logic             held_hit, recl_hit, free_hit;
  logic [IDX_W-1:0] held_slot, recl_slot, free_slot;

  always_comb begin
    held_hit  = 1'b0;
    recl_hit  = 1'b0;
    free_hit  = 1'b0;
    held_slot = '0;
    recl_slot = '0;
    free_slot = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (owner_id[i] == in_req.device && !free_flag[i]) begin
        held_hit  = 1'b1;
        held_slot = IDX_W'(i);
      end
      if (owner_id[i] == in_req.device && free_flag[i]) begin
        recl_hit  = 1'b1;
        recl_slot = IDX_W'(i);
      end
      if (free_flag[i]) begin
        free_hit  = 1'b1;
        free_slot = IDX_W'(i);
      end
    end
  end

  // Request decode: grant slot, what gets written, and the result.
  logic             is_alloc;
  logic             ok_c;
  logic [IDX_W-1:0] slot;
  logic             take_new;
  logic             mark_busy;
  logic             free_ok;
  logic [IDX_W-1:0] ch_idx;
  logic [3:0]       dev_nib;
  logic [MUX_W-1:0] mux_next;

  assign is_alloc = (in_req.func == FUNC_ALLOC);
  assign ch_idx   = in_req.channel[IDX_W-1:0];
  assign free_ok  = (in_req.channel < CH_W'(CHANNELS));
  assign dev_nib  = 4'(in_req.device & DEVICE_NIBBLE);

  always_comb begin
    slot      = '0;
    take_new  = 1'b0;
    mark_busy = 1'b0;
    if (held_hit) begin
      slot = held_slot;
    end else if (recl_hit) begin
      slot      = recl_slot;
      mark_busy = 1'b1;
    end else if (free_hit) begin
      slot      = free_slot;
      take_new  = 1'b1;
      mark_busy = 1'b1;
    end
    ok_c = is_alloc ? (held_hit || recl_hit || free_hit) : free_ok;
  end

  // Only the newly taken channel's nibble of the mux map changes, and only
  // on an allocate.
  always_comb begin
    mux_next = mux_word;
    for (int i = 0; i < CHANNELS; i++) begin
      if (is_alloc && take_new && slot == IDX_W'(i)) begin
        mux_next[4*i +: 4] = dev_nib;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
      free_flag <= '1;
      mux_word  <= MUX_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        owner_id[i] <= DEV_W'(i);
      end
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_req   <= req_t'({s_tuser, s_tdata[DEV_W-1:0], s_tdata[DEV_W+CH_W-1:DEV_W]});
      end else if (proc) begin
        in_valid <= 1'b0;
      end

      if (proc) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (proc) begin
        if (is_alloc) begin
          if (mark_busy) begin
            free_flag[slot] <= 1'b0;
          end
          if (take_new) begin
            owner_id[slot] <= in_req.device;
            mux_word       <= mux_next;
          end
        end else if (free_ok) begin
          free_flag[ch_idx] <= 1'b1;
        end
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (proc) begin
      m_tuser <= ok_c;
      m_tdata <= {(M_DATA_W - GRANT_W - MUX_W)'(0), mux_next,
                  (is_alloc && ok_c) ? GRANT_W'(slot) : GRANT_W'(0)};
    end
  end

`ifndef SYNTHESIS
  // A granted channel is busy once the grant is done.
  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    proc && is_alloc && ok_c |=> !free_flag[$past(slot)])
    else $error("granted channel still marked free");

  // A successful free leaves the channel free.
  a_free_done: assert property (@(posedge clk) disable iff (rst)
    proc && !is_alloc && ok_c |=> free_flag[$past(ch_idx)])
    else $error("freed channel not marked free");

  // A failed request changes nothing in the mux map.
  a_fail_mux: assert property (@(posedge clk) disable iff (rst)
    proc && !ok_c |=> $stable(mux_word))
    else $error("mux map changed on a failed request");

  // A held item is not dropped while the result register is stalled.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |=> in_valid)
    else $error("pending item lost during output stall");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the sticky DMA channel allocator.
// A queue of requests feeds a stream driver; a monitor predicts each accepted
// request against a shadow owner table and checks every result item in order.
module testbench;
  import dca_pkg::*;

  // One expected result item: ok flag, granted channel, mux word after the step.
  typedef struct packed {
    logic               ok;
    logic [GRANT_W-1:0] grant;
    logic [MUX_W-1:0]   mux;
  } grant_res_t;

  // A pending request, or a sync point where the sender waits for all results.
  typedef struct {
    req_t req;
    bit   sync;
  } pending_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  dma_channel_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the allocator state.
  logic [DEV_W-1:0] owner_tab [CHANNELS];
  bit               free_tab  [CHANNELS];
  logic [MUX_W-1:0] mux_shadow;

  pending_t   req_q[$];
  grant_res_t grant_q[$];

  bit in_taken;
  bit out_taken;
  int gap_left;
  int stall_left;
  bit long_stall_done;

  int items_in;
  int results_seen;
  int err_count;
  int n_held, n_reclaim, n_fresh, n_full, n_freed, n_bad_free;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string what);
    if (err_count < 40) begin
      $display("mismatch at %0t, result %0d: %s", $realtime, results_seen, what);
    end
    err_count++;
  endtask

  function automatic void reset_shadow();
    for (int i = 0; i < CHANNELS; i++) begin
      owner_tab[i] = DEV_W'(i);
      free_tab[i]  = 1'b1;
    end
    mux_shadow = MUX_RESET;
  endfunction

  // Applies one request to the shadow table and returns what the block must answer.
  function automatic grant_res_t step_allocator(input req_t r);
    grant_res_t res;
    int         slot;
    logic [DEV_W-1:0] nib;
    res  = '0;
    slot = -1;
    if (r.func == FUNC_ALLOC) begin
      // Search from the top down so the lowest match wins.
      for (int i = CHANNELS - 1; i >= 0; i--) begin
        if (owner_tab[i] == r.device && !free_tab[i]) slot = i;
      end
      if (slot >= 0) begin
        n_held++;
      end else begin
        for (int i = CHANNELS - 1; i >= 0; i--) begin
          if (owner_tab[i] == r.device && free_tab[i]) slot = i;
        end
        if (slot >= 0) begin
          // Sticky reclaim: the mux nibble stays as it was.
          free_tab[slot] = 1'b0;
          n_reclaim++;
        end else begin
          for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (free_tab[i]) slot = i;
          end
          if (slot >= 0) begin
            nib = r.device & DEVICE_NIBBLE;
            owner_tab[slot] = r.device;
            free_tab[slot]  = 1'b0;
            mux_shadow[slot*4 +: 4] = nib[3:0];
            n_fresh++;
          end else begin
            n_full++;
          end
        end
      end
      if (slot >= 0) begin
        res.ok    = 1'b1;
        res.grant = GRANT_W'(slot);
      end
    end else if (r.channel < CHANNELS) begin
      free_tab[r.channel] = 1'b1;
      res.ok = 1'b1;
      n_freed++;
    end else begin
      n_bad_free++;
    end
    res.mux = mux_shadow;
    return res;
  endfunction

  // Monitor: predicts on input handshakes, checks on output handshakes.
  always @(posedge clk) begin
    req_t       seen;
    grant_res_t want;
    if (!rst && s_tvalid && s_tready) begin
      seen.func    = func_t'(s_tuser);
      seen.device  = s_tdata[15:0];
      seen.channel = s_tdata[19:16];
      grant_q.push_back(step_allocator(seen));
      items_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (grant_q.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = grant_q.pop_front();
        if (m_tuser !== want.ok)
          report($sformatf("ok %b, expected %b", m_tuser, want.ok));
        if (m_tdata[2:0] !== want.grant)
          report($sformatf("granted_channel %0d, expected %0d", m_tdata[2:0], want.grant));
        if (m_tdata[34:3] !== want.mux)
          report($sformatf("mux_map %h, expected %h", m_tdata[34:3], want.mux));
        if (m_tdata[39:35] !== 5'd0)
          report($sformatf("pad bits %b, expected zero", m_tdata[39:35]));
      end
      results_seen++;
    end
    in_taken  <= !rst && s_tvalid && s_tready;
    out_taken <= !rst && m_tvalid && m_tready;
  end

  // Driver: offers the head of the request queue after a random gap.
  always @(negedge clk) begin
    bit quiet;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      quiet = ((items_in / 160) % 3) == 2;
      if (in_taken) begin
        void'(req_q.pop_front());
        gap_left = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (req_q.size() != 0 && req_q[0].sync) begin
        // Sender pause: hold off until every expected result has come back.
        if (grant_q.size() == 0) void'(req_q.pop_front());
        s_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, req_q[0].req.channel, req_q[0].req.device};
        s_tuser  <= req_q[0].req.func;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls a random number of cycles after each result, plus one long
  // hold-off that lets the pipeline fill and back-pressure the input.
  always @(negedge clk) begin
    bit quiet;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      quiet = ((results_seen / 140) % 3) == 1;
      if (out_taken) begin
        if (results_seen >= 700 && !long_stall_done) begin
          stall_left = 400;
          long_stall_done = 1'b1;
        end else begin
          stall_left = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input func_t f, input logic [DEV_W-1:0] dev,
                           input logic [CH_W-1:0] ch);
    pending_t p;
    p.req.func    = f;
    p.req.device  = dev;
    p.req.channel = ch;
    p.sync        = 1'b0;
    req_q.push_back(p);
  endtask

  task automatic queue_sync();
    pending_t p;
    p.req  = '0;
    p.sync = 1'b1;
    req_q.push_back(p);
  endtask

  initial begin
    logic [DEV_W-1:0] pool [12];
    int               pick;
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    gap_left  = 0;
    stall_left = 0;
    reset_shadow();

    // Directed part.
    // Device 3 matches the stale owner left by reset, so it reclaims channel 3.
    queue_req(FUNC_ALLOC, 16'd3, 4'd0);
    queue_req(FUNC_ALLOC, 16'd3, 4'd9);        // already holds channel 3
    queue_req(FUNC_ALLOC, 16'hffff, 4'd0);     // fresh grant of channel 0
    queue_req(FUNC_ALLOC, 16'h8000, 4'd15);
    queue_req(FUNC_ALLOC, 16'h1234, 4'd0);
    queue_req(FUNC_ALLOC, 16'habcd, 4'd0);
    queue_req(FUNC_ALLOC, 16'h5a5a, 4'd0);
    queue_req(FUNC_ALLOC, 16'h00f0, 4'd0);
    queue_req(FUNC_ALLOC, 16'h7fff, 4'd0);     // table now full
    queue_req(FUNC_ALLOC, 16'h0001, 4'd0);     // no channel available
    queue_req(FUNC_FREE, 16'h0000, 4'd8);      // channel numbers out of range
    queue_req(FUNC_FREE, 16'hffff, 4'd15);
    queue_req(FUNC_FREE, 16'h0000, 4'd2);
    queue_req(FUNC_FREE, 16'h0000, 4'd2);      // freeing a channel that is free
    queue_req(FUNC_ALLOC, 16'h1234, 4'd0);     // reclaim, mux left alone
    queue_req(FUNC_FREE, 16'h0000, 4'd0);
    queue_req(FUNC_ALLOC, 16'h2222, 4'd0);     // takes over channel 0 from 0xffff
    queue_req(FUNC_ALLOC, 16'hffff, 4'd0);     // stale owner lost, table full again
    queue_req(FUNC_FREE, 16'h0000, 4'd7);
    queue_req(FUNC_FREE, 16'h0000, 4'd6);
    queue_req(FUNC_ALLOC, 16'h00f0, 4'd0);     // reclaims channel 6
    queue_req(FUNC_ALLOC, 16'h0007, 4'd0);     // fresh grant of channel 7
    queue_sync();

    // Random part: allocations mostly from a small pool of devices so that held,
    // reclaimed and full-table cases keep recurring; the pool changes per phase.
    for (int n = 0; n < 1900; n++) begin
      if (n % 300 == 0) begin
        foreach (pool[k]) begin
          pool[k] = ($urandom_range(0, 3) == 0) ? DEV_W'($urandom_range(0, 15))
                                                 : DEV_W'($urandom_range(0, 65535));
        end
      end
      if (n == 1200) queue_sync();
      pick = $urandom_range(0, 99);
      if (pick < 55)
        queue_req(FUNC_ALLOC, pool[$urandom_range(0, 11)], 4'($urandom_range(0, 15)));
      else if (pick < 65)
        queue_req(FUNC_ALLOC, DEV_W'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
      else if (pick < 94)
        queue_req(FUNC_FREE, DEV_W'($urandom_range(0, 65535)), 4'($urandom_range(0, 7)));
      else
        queue_req(FUNC_FREE, DEV_W'($urandom_range(0, 65535)), 4'($urandom_range(8, 15)));
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || grant_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: %0d held, %0d reclaimed, %0d fresh, %0d refused",
             items_in, n_held, n_reclaim, n_fresh, n_full);
    $display("frees: %0d accepted, %0d out of range; %0d results checked",
             n_freed, n_bad_free, results_seen);
    if (err_count == 0) begin
      $display("[dma_channel_allocator_core] OK");
    end else begin
      $display("[dma_channel_allocator_core] ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("timeout with %0d results outstanding", grant_q.size());
    $display("[dma_channel_allocator_core] ERROR");
    $finish;
  end

endmodule
